// ===== rtl/sxfr_pkg.sv =====
// shared types and constants for the sync xor frame receiver
`timescale 1ns / 1ps

package sxfr_pkg;

  localparam logic [7:0] SYNC_RESET  = 8'hBB;
  localparam int         BYTE_W      = 8;
  localparam int         INDEX_W     = 3;

  // receive phase of the frame parser
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  // one queued frame verdict
  typedef struct packed {
    logic bad;
    logic bank;
  } cmd_t;

  // payload bank handed back once fully read
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// ===== rtl/sync_xor_frame_receiver_core.sv =====
// top level of the sync xor frame receiver
`timescale 1ns / 1ps

// Receives bytes on the slave stream, one per transaction. In idle a byte equal
// to the sync register (reset 0xBB) opens a frame and seeds an xor check; the
// next PAYLOAD_BYTES bytes are stored and folded into the check, and the byte
// after them is compared with it. A match produces PAYLOAD_BYTES master
// transactions holding the payload in order, byte index in tdata[10:8] and
// tlast on the final one; a mismatch produces a single transaction with tuser
// set, zero payload and tlast. Input bytes are taken at one per cycle: the
// parser writes payload into one of two ram banks while the emitter drains the
// other at one result per cycle while the master side is ready, through the
// ram read port, so a frame stalls the input only when its payload arrives
// while both banks are still draining or the two entry verdict queue is full.
// A verdict passes the queue, the read stage and the output register. The
// sync register may be changed only while no frame is in progress.

module sync_xor_frame_receiver_core #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // sync byte register
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] byte_index, rest zero
  output logic        m_axis_tlast,   // last_byte
  output logic [0:0]  m_axis_tuser    // [0] bad_check
);

  localparam int IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int RAM_DEPTH = 2 * (1 << IDX_W);

  logic [7:0]          sync_byte;

  // payload ram, two banks of 2**IDX_W entries, PAYLOAD_BYTES used in each
  logic                ram_we;
  logic [IDX_W:0]      ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [IDX_W:0]      ram_raddr;
  logic [7:0]          ram_rdata;

  // verdict queue
  logic                cmd_push;
  sxfr_pkg::cmd_t      push_cmd;
  logic                cmd_full;
  logic                cmd_pop;
  logic                cmd_valid;
  sxfr_pkg::cmd_t      head_cmd;
  sxfr_pkg::release_t  rel;

  logic [7:0]          out_payload;
  logic [2:0]          out_index;
  logic                out_bad;

  // sync byte register, to be written only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= sxfr_pkg::SYNC_RESET;
    end else if (cfg_wen) begin
      sync_byte <= cfg_wdata;
    end
  end

  sxfr_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_byte),
    .rx_valid  (s_axis_tvalid),
    .rx_ready  (s_axis_tready),
    .rx_byte   (s_axis_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .cmd_full  (cmd_full),
    .rel       (rel)
  );

  sxfr_ram #(
    .WIDTH (sxfr_pkg::BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sxfr_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (head_cmd)
  );

  sxfr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .IDX_W         (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .rel         (rel),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_payload (out_payload),
    .out_index   (out_index),
    .out_last    (m_axis_tlast),
    .out_bad     (out_bad)
  );

  assign m_axis_tdata = {5'd0, out_index, out_payload};
  assign m_axis_tuser = out_bad;

  // a bad-check result is always a lone, zeroed, last transaction
  a_bad_is_last : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 16'd0))
    else $error("bad-check result malformed");

  // the parser never pushes into a full verdict queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("verdict queue overflow");

  // the emitter only consumes a verdict that is present
  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("verdict queue underflow");

  // a payload read never targets the bank being filled by the parser
  a_bank_apart : assert property (@(posedge clk) disable iff (rst)
    ram_re && ram_we |-> ram_raddr[IDX_W] != ram_waddr[IDX_W])
    else $error("payload bank read while being written");

endmodule

// ===== rtl/sxfr_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sxfr_cmd_fifo.sv =====
// two entry queue of frame verdicts between parser and emitter
`timescale 1ns / 1ps

module sxfr_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sxfr_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sxfr_pkg::cmd_t    head
);

  sxfr_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sxfr_front.sv =====
// frame parser: sync hunt, payload capture into banked ram, check compare
`timescale 1ns / 1ps

module sxfr_front #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int IDX_W         = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           sync_byte,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic [7:0]           rx_byte,
  output logic                 ram_we,
  output logic [IDX_W:0]       ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic                 cmd_push,
  output sxfr_pkg::cmd_t       cmd,
  input  logic                 cmd_full,
  input  sxfr_pkg::release_t   rel
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  sxfr_pkg::phase_t phase, phase_next;
  logic [IDX_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_check, running_check_next;
  logic             wr_bank, wr_bank_next;
  logic [1:0]       busy, busy_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sxfr_pkg::PH_IDLE;
      byte_count    <= '0;
      running_check <= '0;
      wr_bank       <= 1'b0;
      busy          <= '0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      running_check <= running_check_next;
      wr_bank       <= wr_bank_next;
      busy          <= busy_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    running_check_next = running_check;
    wr_bank_next       = wr_bank;
    busy_next          = busy;
    rx_ready           = 1'b1;
    ram_we             = 1'b0;
    ram_waddr          = {wr_bank, byte_count};
    ram_wdata          = rx_byte;
    cmd_push           = 1'b0;
    cmd.bad            = (rx_byte != running_check);
    cmd.bank           = wr_bank;

    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end

    case (phase)
      sxfr_pkg::PH_IDLE: begin
        rx_ready = 1'b1;
      end
      sxfr_pkg::PH_DATA: begin
        // wait until the emitter has drained this bank
        rx_ready = ~busy[wr_bank];
      end
      sxfr_pkg::PH_CHECK: begin
        rx_ready = ~cmd_full;
      end
      default: begin
        rx_ready = 1'b1;
      end
    endcase

    accept = rx_valid & rx_ready;

    if (accept) begin
      case (phase)
        sxfr_pkg::PH_IDLE: begin
          if (rx_byte == sync_byte) begin
            phase_next         = sxfr_pkg::PH_DATA;
            byte_count_next    = '0;
            running_check_next = rx_byte;
          end
        end
        sxfr_pkg::PH_DATA: begin
          ram_we             = 1'b1;
          running_check_next = running_check ^ rx_byte;
          if (byte_count == LAST_IDX) begin
            byte_count_next = '0;
            phase_next      = sxfr_pkg::PH_CHECK;
          end else begin
            byte_count_next = byte_count + 1'b1;
          end
        end
        sxfr_pkg::PH_CHECK: begin
          cmd_push        = 1'b1;
          byte_count_next = '0;
          phase_next      = sxfr_pkg::PH_IDLE;
          if (!cmd.bad) begin
            busy_next[wr_bank] = 1'b1;
            wr_bank_next       = ~wr_bank;
          end
        end
        default: begin
          byte_count_next = '0;
          phase_next      = sxfr_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sxfr_back.sv =====
// result emitter: reads a good frame from ram or issues a bad-check result
`timescale 1ns / 1ps

module sxfr_back #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int IDX_W         = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  sxfr_pkg::cmd_t        cmd,
  output logic                  cmd_pop,
  output sxfr_pkg::release_t    rel,
  output logic                  ram_re,
  output logic [IDX_W:0]        ram_raddr,
  input  logic [7:0]            ram_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_payload,
  output logic [2:0]            out_index,
  output logic                  out_last,
  output logic                  out_bad
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  logic [IDX_W-1:0] rd_idx;
  logic             issue;
  logic             issue_last;
  logic             out_free;
  logic             s1_adv;
  logic [IDX_W+2:0] idx_ext;

  // stage one: ram read in flight
  logic             s1_valid;
  logic             s1_bad;
  logic [2:0]       s1_index;
  logic             s1_last;

  assign out_free   = ~out_valid | out_ready;
  assign s1_adv     = s1_valid & out_free;
  assign issue      = cmd_valid & (~s1_valid | s1_adv);
  assign issue_last = cmd.bad | (rd_idx == LAST_IDX);
  assign cmd_pop    = issue & issue_last;
  assign rel.valid  = cmd_pop & ~cmd.bad;
  assign rel.bank   = cmd.bank;
  assign ram_re     = issue & ~cmd.bad;
  assign ram_raddr  = {cmd.bank, rd_idx};
  assign idx_ext    = (IDX_W + 3)'(rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_idx <= issue_last ? '0 : rd_idx + 1'b1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_bad   <= cmd.bad;
      s1_index <= cmd.bad ? 3'd0 : idx_ext[2:0];
      s1_last  <= issue_last;
    end
    if (s1_adv) begin
      out_payload <= s1_bad ? 8'd0 : ram_rdata;
      out_index   <= s1_index;
      out_last    <= s1_last;
      out_bad     <= s1_bad;
    end
  end

endmodule

// ===== test/tb_sync_xor_frame_receiver_core.sv =====
// self-checking testbench for the sync xor frame receiver core
`timescale 1ns / 1ps

module tb_sync_xor_frame_receiver_core;

  localparam int FRAME_LEN     = 8;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 64;
  localparam int SETTLE_CYCLES = 12;  // keep margin after the last verdict
  localparam int REPORT_MAX    = 10;
  localparam int SYNC_PHASES   = 4;

  // one master-side transaction, split into its fields
  typedef struct packed {
    logic [sxfr_pkg::BYTE_W-1:0]  payload;
    logic [sxfr_pkg::INDEX_W-1:0] index;
    logic                         last;
    logic                         bad;
  } rx_result_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_SILENT,     // no transaction may follow this byte
    ROW_BAD_CHECK,  // check byte mismatch, single bad verdict
    ROW_PREDICTED   // results come from the frame parser model
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [sxfr_pkg::BYTE_W-1:0] rx;
  } dir_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_PERIODIC,
    RDY_SPARSE
  } ready_mode_t;

  localparam rx_result_t BAD_VERDICT = {8'h00, 3'd0, 1'b1, 1'b1};

  localparam int DIR_ROWS = 23;
  // frame a: extremes in the payload, check 0xff
  // frame b: check byte equals the sync byte but does not match
  localparam dir_row_t [0:DIR_ROWS-1] DIRECTED = {
    {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'hFF},
    {ROW_SILENT, 8'hBB},
    {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'hFF}, {ROW_SILENT, 8'h55}, {ROW_SILENT, 8'hAA},
    {ROW_SILENT, 8'h01}, {ROW_SILENT, 8'h80}, {ROW_SILENT, 8'hBB}, {ROW_SILENT, 8'h7E},
    {ROW_PREDICTED, 8'hFF},
    {ROW_SILENT, 8'hBB},
    {ROW_SILENT, 8'h01}, {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'h00},
    {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'h00}, {ROW_SILENT, 8'h00},
    {ROW_BAD_CHECK, 8'hBB},
    {ROW_SILENT, 8'h55}  // idle again: must not be taken as payload
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wen       = 1'b0;
  logic [7:0]  cfg_wdata     = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [7:0] payload_byte, [10:8] byte_index
  logic        m_axis_tlast;            // last_byte
  logic [0:0]  m_axis_tuser;            // [0] bad_check

  // frame parser model state
  logic [sxfr_pkg::BYTE_W-1:0] sync_value = sxfr_pkg::SYNC_RESET;
  sxfr_pkg::phase_t            rx_phase   = sxfr_pkg::PH_IDLE;
  int                          rx_count   = 0;
  logic [sxfr_pkg::BYTE_W-1:0] rx_xor     = '0;
  logic [sxfr_pkg::BYTE_W-1:0] rx_store [FRAME_LEN];

  rx_result_t  fresh_results [$];
  rx_result_t  awaited_bytes [$];
  int          fail_count  = 0;
  int          burst_left  = 0;
  int          cycle_count = 0;
  ready_mode_t ready_mode  = RDY_ALWAYS;
  int          mode_left   = 0;

  sync_xor_frame_receiver_core #(
    .PAYLOAD_BYTES(FRAME_LEN)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_HALF) clk = ~clk;

  // frame parser model: one received byte in, its results in fresh_results
  function automatic void parse_rx_byte(input logic [sxfr_pkg::BYTE_W-1:0] b);
    rx_result_t r;
    fresh_results.delete();
    case (rx_phase)
      sxfr_pkg::PH_IDLE: begin
        if (b == sync_value) begin
          rx_phase = sxfr_pkg::PH_DATA;
          rx_count = 0;
          rx_xor   = b;
        end
      end
      sxfr_pkg::PH_DATA: begin
        rx_store[rx_count] = b;
        rx_xor = rx_xor ^ b;
        rx_count++;
        if (rx_count == FRAME_LEN) begin
          rx_count = 0;
          rx_phase = sxfr_pkg::PH_CHECK;
        end
      end
      sxfr_pkg::PH_CHECK: begin
        if (b == rx_xor) begin
          for (int k = 0; k < FRAME_LEN; k++) begin
            r.payload = rx_store[k];
            r.index   = k[sxfr_pkg::INDEX_W-1:0];
            r.last    = (k == FRAME_LEN - 1);
            r.bad     = 1'b0;
            fresh_results.push_back(r);
          end
        end else begin
          fresh_results.push_back(BAD_VERDICT);
        end
        rx_count = 0;
        rx_phase = sxfr_pkg::PH_IDLE;
      end
      default: begin
        rx_count = 0;
        rx_phase = sxfr_pkg::PH_IDLE;
      end
    endcase
  endfunction

  // one slave transaction; bursts of random length with random gaps between
  task automatic send_rx(input logic [sxfr_pkg::BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic feed_byte(input logic [sxfr_pkg::BYTE_W-1:0] b, input row_kind_t kind);
    send_rx(b);
    parse_rx_byte(b);
    case (kind)
      ROW_BAD_CHECK: awaited_bytes.push_back(BAD_VERDICT);
      ROW_PREDICTED: foreach (fresh_results[i]) awaited_bytes.push_back(fresh_results[i]);
      default: ;
    endcase
  endtask

  // full frame with random payload; good or broken check byte
  task automatic send_frame(input bit good);
    logic [sxfr_pkg::BYTE_W-1:0] body [FRAME_LEN];
    logic [sxfr_pkg::BYTE_W-1:0] sum;
    logic [sxfr_pkg::BYTE_W-1:0] chk;
    foreach (body[i]) begin
      body[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) body[i] = sync_value;
    end
    // sometimes zero xor over the payload so the check byte equals the sync byte
    if ($urandom_range(0, 5) == 0) begin
      body[FRAME_LEN-1] = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) body[FRAME_LEN-1] ^= body[i];
    end
    sum = sync_value;
    foreach (body[i]) sum ^= body[i];
    if (good) chk = sum;
    else if ($urandom_range(0, 3) == 0 && sync_value != sum) chk = sync_value;
    else chk = sum ^ 8'($urandom_range(1, 255));
    feed_byte(sync_value, ROW_PREDICTED);
    foreach (body[i]) feed_byte(body[i], ROW_PREDICTED);
    feed_byte(chk, ROW_PREDICTED);
  endtask

  // sender holds off until every expected transaction has come
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [sxfr_pkg::BYTE_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sync_value = v;
  endtask

  task automatic check_result();
    rx_result_t seen;
    rx_result_t want;
    seen.payload = m_axis_tdata[sxfr_pkg::BYTE_W-1:0];
    seen.index   = m_axis_tdata[sxfr_pkg::BYTE_W+sxfr_pkg::INDEX_W-1:sxfr_pkg::BYTE_W];
    seen.last    = m_axis_tlast;
    seen.bad     = m_axis_tuser[0];
    if (awaited_bytes.size() == 0) begin
      if (fail_count < REPORT_MAX)
        $display("unexpected result: payload %h index %0d last %b bad %b",
                 seen.payload, seen.index, seen.last, seen.bad);
      fail_count++;
    end else begin
      want = awaited_bytes.pop_front();
      if (seen !== want) begin
        if (fail_count < REPORT_MAX)
          $display("mismatch: expected payload %h index %0d last %b bad %b, got %h %0d %b %b",
                   want.payload, want.index, want.last, want.bad,
                   seen.payload, seen.index, seen.last, seen.bad);
        fail_count++;
      end
    end
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 160);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS:   m_axis_tready <= 1'b1;
      RDY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: m_axis_tready <= ((cycle_count % 5) < 2);
      default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sync_xor_frame_receiver_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int                          done;
    int                          pick;
    int                          noise_n;
    logic [sxfr_pkg::BYTE_W-1:0] new_sync;
    logic [sxfr_pkg::BYTE_W-1:0] b;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed rows with the reset sync byte
    for (int r = 0; r < DIR_ROWS; r++) feed_byte(DIRECTED[r].rx, DIRECTED[r].kind);

    // random frames under several sync settings, extremes first
    for (int p = 0; p < SYNC_PHASES; p++) begin
      drain_results();
      case (p)
        0:       new_sync = 8'h00;
        1:       new_sync = 8'hFF;
        default: new_sync = 8'($urandom_range(0, 255));
      endcase
      write_sync(new_sync);
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // line noise in idle, ignored by the block
          noise_n = $urandom_range(1, 3);
          repeat (noise_n) begin
            b = 8'($urandom_range(0, 255));
            if (b == sync_value) b ^= 8'h01;
            feed_byte(b, ROW_PREDICTED);
          end
        end else begin
          send_frame(pick < 8);
          done += FRAME_LEN + 2;
        end
        if ($urandom_range(0, 11) == 0) drain_results();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sync_xor_frame_receiver_core: PASSED **");
    end else begin
      $display("** sync_xor_frame_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule
